### hw/rtl/mwrp_pkg.sv
// Shared types and constants for the minimum weight range path block.
`default_nettype none
package mwrp_pkg;
   localparam int NodeW    = 10;
   localparam int WeightW  = 16;
   localparam int CountW   = 11;
   localparam int MaxNodes = 1024;

   typedef struct packed {
      logic [WeightW-1:0] weight;
      logic [NodeW-1:0]   end_b;
      logic [NodeW-1:0]   end_a;
   } edge_type;
endpackage
`default_nettype wire

### hw/rtl/mwrp_edge_store.sv
// Weight-ordered edge memory with one write and one registered read port.
`default_nettype none
module mwrp_edge_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire mwrp_pkg::edge_type wr_data,
   input  wire logic [AW-1:0]     rd_addr,
   output mwrp_pkg::edge_type     rd_data
);
   mwrp_pkg::edge_type mem [DEPTH];
   mwrp_pkg::edge_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule
`default_nettype wire

### hw/rtl/mwrp_node_mem.sv
// Per-node memory: one write and one registered read port.
`default_nettype none
module mwrp_node_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 1
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [DW-1:0]      rd_data
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule
`default_nettype wire

### hw/rtl/min_weight_range_path.sv
// Top level: edge loading, window search and reachability sweep.
// Usage:
//   req_ channel carries one edge per request: tdata = {weight, end_b, end_a}
//   and tlast marks the final edge of a graph. Loading does an ordered
//   insertion: each held edge of greater weight is read, compared and shifted
//   up one entry, then the new edge is written. req_tready stays low meanwhile,
//   so the next request is taken only once the insertion is done.
//   After the final edge the search slides a window [low, high] over the
//   sorted edges. Each window is tested by relaxation sweeps: each sweep
//   reads every window edge, probes the reach map for both endpoints and,
//   when both lie below node_count and exactly one is reached, marks the other
//   reached; sweeps repeat until one adds nothing. Each window test starts
//   with a clear of node_count entries of the reach map.
//   One result per graph leaves on rsp_: tdata = {found, spread}.
//   Reset empties the edge store and sets node_count to 2; the reach map is
//   cleared before every window test so no clearing pass is needed at reset.
//   No request is taken during insertion or search. A finished search waits
//   while an earlier result is still held on rsp_; no edges of the next graph
//   load meanwhile. csr_ writes only while idle.
`default_nettype none
module min_weight_range_path #(
   parameter int MAX_EDGES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // end_a[9:0], end_b[19:10], weight[35:20]
   input  wire logic        req_tlast,   // last_edge
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // spread[15:0], found[16]
   input  wire logic        csr_wen,
   input  wire logic [10:0] csr_wdata    // node_count
);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int NAW = $clog2(mwrp_pkg::MaxNodes);
   localparam int NCW = $clog2(mwrp_pkg::MaxNodes + 1);
   localparam int WW  = mwrp_pkg::WeightW;

   typedef enum logic [3:0] {
      S_IDLE, S_INS_RD, S_INS_CMP, S_INS_WR, S_CLR, S_SEED, S_RD, S_EDGE,
      S_CHK, S_WLO, S_WLO2, S_NEXT, S_OUT
   } state_type;

   state_type          state_ff;
   logic [10:0]        ncount_ff;
   logic [ECW-1:0]     total_ff;
   logic [ECW-1:0]     pos_ff;
   mwrp_pkg::edge_type new_ff;
   logic               last_ff;
   logic [ECW-1:0]     lo_ff, hi_ff, idx_ff;
   logic [NCW-1:0]     clr_ff;
   logic               chg_ff;
   logic [NAW-1:0]     tgt_ff;
   logic [NCW-1:0]     nodes_ff;
   logic [WW:0]        best_ff;
   logic [WW-1:0]      wlo_ff;
   logic [23:0]        rsp_ff;
   logic               rsp_valid_ff;
   // reach-map probe pipeline
   logic [1:0]         ph_ff;
   logic               ra_ff, rb_ff;

   logic               e_we;
   logic [EAW-1:0]     e_wa, e_ra;
   mwrp_pkg::edge_type e_wd, e_rd;
   logic               v_we;
   logic [NAW-1:0]     v_wa, v_ra;
   logic               v_wd, v_rd;

   mwrp_edge_store #(.DEPTH(MAX_EDGES), .AW(EAW)) u_edges (
      .clock(clock), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));

   mwrp_node_mem #(.DEPTH(mwrp_pkg::MaxNodes), .AW(NAW), .DW(1)) u_reach (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(v_ra), .rd_data(v_rd));

   logic           a_ok, b_ok;
   logic [NCW-1:0] ea_w, eb_w;
   assign ea_w = NCW'(e_rd.end_a);
   assign eb_w = NCW'(e_rd.end_b);
   assign a_ok = ea_w < nodes_ff;
   assign b_ok = eb_w < nodes_ff;

   always_comb begin
      e_we = 1'b0;
      e_wa = pos_ff[EAW-1:0];
      e_wd = new_ff;
      e_ra = idx_ff[EAW-1:0];
      v_we = 1'b0;
      v_wa = clr_ff[NAW-1:0];
      v_wd = 1'b0;
      v_ra = (ph_ff == 2'd0) ? e_rd.end_a[NAW-1:0] : e_rd.end_b[NAW-1:0];
      case (state_ff)
         S_INS_RD:  e_ra = pos_ff[EAW-1:0] - EAW'(1);
         S_INS_CMP: begin
            if (pos_ff != '0 && e_rd.weight > new_ff.weight) begin
               e_we = 1'b1;
               e_wd = e_rd;
            end
         end
         S_INS_WR:  e_we = 1'b1;
         S_CLR:     v_we = 1'b1;
         S_SEED: begin
            v_we = 1'b1;
            v_wa = '0;
            v_wd = 1'b1;
         end
         S_EDGE: begin
            if (ph_ff == 2'd2 && a_ok && b_ok && (ra_ff != v_rd)) begin
               v_we = 1'b1;
               v_wa = ra_ff ? e_rd.end_b[NAW-1:0] : e_rd.end_a[NAW-1:0];
               v_wd = 1'b1;
            end
         end
         S_CHK:     v_ra = tgt_ff;
         S_WLO:     e_ra = lo_ff[EAW-1:0];
         S_WLO2:    e_ra = hi_ff[EAW-1:0];
         default: ;
      endcase
   end

   logic [NCW-1:0] neff;
   always_comb begin
      neff = (ncount_ff == '0) ? NCW'(1)
           : (ncount_ff > 11'(mwrp_pkg::MaxNodes)) ? NCW'(mwrp_pkg::MaxNodes)
           : NCW'(ncount_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ncount_ff    <= 11'd2;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ph_ff        <= '0;
      end else begin
         if (csr_wen) ncount_ff <= csr_wdata;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  new_ff  <= req_tdata[35:0];
                  last_ff <= req_tlast;
                  pos_ff  <= total_ff;
                  if (total_ff >= ECW'(MAX_EDGES)) begin
                     if (req_tlast) begin
                        lo_ff <= '0; hi_ff <= '0; best_ff <= '1;
                        nodes_ff <= neff; tgt_ff <= NAW'(neff - NCW'(1));
                        state_ff <= S_NEXT;
                     end
                  end else begin
                     state_ff <= S_INS_RD;
                  end
               end
            end
            S_INS_RD:  state_ff <= S_INS_CMP;
            S_INS_CMP: begin
               if (pos_ff != '0 && e_rd.weight > new_ff.weight) begin
                  pos_ff   <= pos_ff - ECW'(1);
                  state_ff <= S_INS_RD;
               end else begin
                  state_ff <= S_INS_WR;
               end
            end
            S_INS_WR: begin
               total_ff <= total_ff + ECW'(1);
               if (last_ff) begin
                  lo_ff <= '0; hi_ff <= '0; best_ff <= '1;
                  nodes_ff <= neff; tgt_ff <= NAW'(neff - NCW'(1));
                  state_ff <= S_NEXT;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_NEXT: begin
               if (lo_ff < total_ff && hi_ff < total_ff) begin
                  if (lo_ff > hi_ff) begin
                     hi_ff <= hi_ff + ECW'(1);
                  end else begin
                     clr_ff   <= '0;
                     state_ff <= S_CLR;
                  end
               end else if (!rsp_valid_ff) begin
                  rsp_ff       <= {7'd0, ~best_ff[WW],
                                   best_ff[WW] ? 16'd0 : best_ff[WW-1:0]};
                  rsp_valid_ff <= 1'b1;
                  total_ff     <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            S_CLR: begin
               clr_ff <= clr_ff + NCW'(1);
               if (clr_ff == nodes_ff - NCW'(1)) state_ff <= S_SEED;
            end
            S_SEED: begin
               idx_ff   <= lo_ff;
               chg_ff   <= 1'b0;
               ph_ff    <= '0;
               state_ff <= S_RD;
            end
            S_RD: begin
               ph_ff    <= '0;
               state_ff <= S_EDGE;
            end
            S_EDGE: begin
               // ph 0: edge data valid, probe a; 1: a valid, probe b; 2: b valid
               case (ph_ff)
                  2'd0: ph_ff <= 2'd1;
                  2'd1: begin
                     ra_ff <= v_rd;
                     ph_ff <= 2'd2;
                  end
                  default: begin
                     if (a_ok && b_ok && (ra_ff != v_rd)) chg_ff <= 1'b1;
                     if (idx_ff == hi_ff) begin
                        state_ff <= S_CHK;
                     end else begin
                        idx_ff   <= idx_ff + ECW'(1);
                        state_ff <= S_RD;
                     end
                  end
               endcase
            end
            S_CHK: begin
               if (chg_ff) begin
                  idx_ff   <= lo_ff;
                  chg_ff   <= 1'b0;
                  state_ff <= S_RD;
               end else begin
                  state_ff <= S_WLO;
               end
            end
            S_WLO: begin
               ra_ff    <= v_rd | (tgt_ff == '0);
               state_ff <= S_WLO2;
            end
            S_WLO2: begin
               wlo_ff   <= e_rd.weight;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (ra_ff) begin
                  if ({1'b0, e_rd.weight - wlo_ff} < best_ff)
                     best_ff <= {1'b0, e_rd.weight - wlo_ff};
                  lo_ff <= lo_ff + ECW'(1);
               end else begin
                  hi_ff <= hi_ff + ECW'(1);
               end
               state_ff <= S_NEXT;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request taken while busy");
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= ECW'(MAX_EDGES))
      else $error("edge count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped");
endmodule
`default_nettype wire
